// ===== src/frm_pkg.sv =====
`default_nettype none
package frm_pkg;

  localparam int TOT_W = 40;
  localparam int SECS_W = 7;
  localparam int DIV_CNT_W = 6;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] WINDOW_RESET = 16'd2000;
  localparam logic [7:0] LINK_HDR_RESET = 8'd14;

  // ceil(elapsed / 1000) as ((elapsed + 999) * RECIP_1000) >> RECIP_SHIFT, exact below 2^17
  localparam logic [16:0] MS_ROUND_UP = 17'd999;
  localparam logic [17:0] RECIP_1000 = 18'd134218;
  localparam int RECIP_SHIFT = 27;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TOT_W - 1);

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_LINK_HDR = 2'd1;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd2;
  localparam logic [2:0] ST_IP_LEN_MISMATCH = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic [15:0] wire_len;
    logic [15:0] captured_len;
    logic [15:0] eth_type;
    logic [15:0] ip_total_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [47:0] now_ms;
  } pkt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic new_window;
    logic [TOT_W-1:0] flow_total;
    logic [TOT_W-1:0] flow_rate;
  } res_out_t;

  typedef struct packed {
    logic load_in;
    logic check;
    logic idx_clr;
    logic rd;
    logic scan_next;
    logic insert;
    logic full;
    logic hit_calc;
    logic upd;
    logic div_init;
    logic div_step;
    logic emit;
  } frm_cmd_t;

  typedef struct packed {
    logic drop;
    logic empty;
    logic full;
    logic match;
    logic scan_last;
    logic restart;
    logic div_last;
    logic out_full;
  } frm_stat_t;

endpackage
`default_nettype wire

// ===== src/frm_ram.sv =====
`default_nettype none
module frm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/frm_ctrl.sv =====
`default_nettype none
module frm_ctrl
  import frm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire frm_stat_t stat_i,
  output frm_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_CMP, S_MISS, S_HIT, S_UPD, S_DIVINIT, S_DIV, S_EMIT
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:    cmd_o.load_in = accept;
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cmd_o.idx_clr = 1'b1;
      end
      S_RD:      cmd_o.rd = 1'b1;
      S_CMP:     cmd_o.scan_next = !stat_i.match;
      S_MISS: begin
        cmd_o.full = stat_i.full;
        cmd_o.insert = !stat_i.full;
      end
      S_HIT:     cmd_o.hit_calc = 1'b1;
      S_UPD:     cmd_o.upd = 1'b1;
      S_DIVINIT: cmd_o.div_init = 1'b1;
      S_DIV:     cmd_o.div_step = 1'b1;
      S_EMIT:    cmd_o.emit = !stat_i.out_full;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CHECK;
            ready_q <= 1'b0;
          end
        end
        S_CHECK: begin
          if (stat_i.drop) begin
            state_q <= S_EMIT;
          end else if (stat_i.empty) begin
            state_q <= S_MISS;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (stat_i.match) begin
            state_q <= S_HIT;
          end else if (stat_i.scan_last) begin
            state_q <= S_MISS;
          end else begin
            state_q <= S_RD;
          end
        end
        S_MISS: state_q <= S_EMIT;
        S_HIT:  state_q <= S_UPD;
        S_UPD: begin
          state_q <= stat_i.restart ? S_EMIT : S_DIVINIT;
        end
        S_DIVINIT: state_q <= S_DIV;
        S_DIV: begin
          if (stat_i.div_last) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!stat_i.out_full) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/frm_dp.sv =====
`default_nettype none
module frm_dp
  import frm_pkg::*;
#(
  parameter int FLOW_ENTRIES = 256,
  parameter int TIME_BITS = 48
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pkt_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_out_t        out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire frm_cmd_t   cmd_i,
  output frm_stat_t       stat_o
);

  localparam int AW = $clog2(FLOW_ENTRIES);
  localparam int CW = $clog2(FLOW_ENTRIES + 1);
  localparam int EW = 64 + TIME_BITS + TOT_W;

  pkt_in_t             in_q;
  logic [15:0]         window_q;
  logic [7:0]          link_hdr_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       idx_q;
  res_out_t            res_q;
  res_out_t            out_q;
  logic                out_valid_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;

  logic [31:0]          e_src;
  logic [31:0]          e_dst;
  logic [TIME_BITS-1:0] e_start;
  logic [TOT_W-1:0]     e_total;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [TOT_W:0]       sum;
  logic [16:0]          ip_diff;
  logic                 drop;
  logic [2:0]           drop_code;
  logic [TOT_W-1:0]     clen_ext;

  logic                 restart_q;
  logic [15:0]          elapsed_q;
  logic [TOT_W-1:0]     sum_q;
  logic [34:0]          prod_q;
  logic [SECS_W-1:0]    secs;
  logic [SECS_W-1:0]    secs_q;
  logic [SECS_W:0]      rem_q;
  logic [TOT_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [SECS_W:0]      trial;
  logic                 q_bit;

  assign {e_src, e_dst, e_start, e_total} = ram_rdata;
  assign now_t = TIME_BITS'(in_q.now_ms);
  assign elapsed = now_t - e_start;
  assign sum = {1'b0, e_total} + {{(TOT_W - 15){1'b0}}, in_q.captured_len};
  assign clen_ext = {{(TOT_W - 16){1'b0}}, in_q.captured_len};

  // borrow in bit 16 marks a capture shorter than the link header
  assign ip_diff = {1'b0, in_q.captured_len} - {9'd0, link_hdr_q};

  always_comb begin
    drop = 1'b1;
    if (in_q.wire_len != in_q.captured_len) begin
      drop_code = ST_LEN_MISMATCH;
    end else if (in_q.eth_type != ETH_IPV4) begin
      drop_code = ST_NOT_IPV4;
    end else if (ip_diff[16] || (ip_diff[15:0] != in_q.ip_total_len)) begin
      drop_code = ST_IP_LEN_MISMATCH;
    end else begin
      drop_code = ST_COUNTED;
      drop = 1'b0;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = {in_q.src_addr, in_q.dst_addr, now_t, clen_ext};
    if (cmd_i.insert) begin
      ram_we = 1'b1;
    end else if (cmd_i.upd) begin
      ram_we = 1'b1;
      ram_waddr = idx_q[AW-1:0];
      ram_wdata = restart_q ? {e_src, e_dst, now_t, clen_ext}
                            : {e_src, e_dst, e_start, sum_q};
    end
  end

  frm_ram #(
    .WIDTH(EW),
    .DEPTH(FLOW_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign secs = (prod_q[RECIP_SHIFT +: SECS_W] == '0) ? SECS_W'(1)
                                                     : prod_q[RECIP_SHIFT +: SECS_W];
  assign trial = {rem_q[SECS_W-1:0], quo_q[TOT_W-1]};
  assign q_bit = (trial >= {1'b0, secs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.hit_calc) begin
      restart_q <= (elapsed > {{(TIME_BITS - 16){1'b0}}, window_q});
      elapsed_q <= elapsed[15:0];
      sum_q <= sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
    end
    if (cmd_i.upd) begin
      prod_q <= ({1'b0, elapsed_q} + MS_ROUND_UP) * RECIP_1000;
    end
    if (cmd_i.div_init) begin
      secs_q <= secs;
      rem_q <= '0;
      quo_q <= sum_q;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? (trial - {1'b0, secs_q}) : trial;
      quo_q <= {quo_q[TOT_W-2:0], q_bit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end

    if (cmd_i.check) begin
      res_q <= '{status: drop_code, new_window: 1'b0, flow_total: '0, flow_rate: '0};
    end else if (cmd_i.full) begin
      res_q <= '{status: ST_TABLE_FULL, new_window: 1'b0, flow_total: '0, flow_rate: '0};
    end else if (cmd_i.insert || (cmd_i.upd && restart_q)) begin
      res_q <= '{status: ST_COUNTED, new_window: 1'b1, flow_total: clen_ext,
                 flow_rate: clen_ext};
    end else if (cmd_i.upd) begin
      res_q.flow_total <= sum_q;
    end else if (cmd_i.div_step && (div_cnt_q == DIV_LAST)) begin
      res_q.flow_rate <= {quo_q[TOT_W-2:0], q_bit};
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      link_hdr_q <= LINK_HDR_RESET;
      count_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_WINDOW)) begin
        window_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_LINK_HDR)) begin
        link_hdr_q <= cfg_data_i[7:0];
      end
      if (cmd_i.insert) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.drop = drop;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full = (count_q == CW'(FLOW_ENTRIES));
  assign stat_o.match = (e_src == in_q.src_addr) && (e_dst == in_q.dst_addr);
  assign stat_o.scan_last = ((idx_q + 1'b1) == count_q);
  assign stat_o.restart = restart_q;
  assign stat_o.div_last = (div_cnt_q == DIV_LAST);
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== src/per_flow_byte_rate_meter_core.sv =====
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    in_data_i  (pkt_in_t)
// out       out_valid_o / out_ready_i  out_data_o (res_out_t)
// cfg       cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One packet at a time. A dropped packet goes from the check straight to its
// result. Table lookup is a linear scan of the flow RAM, a registered read then
// a compare for each stored flow. A new flow is inserted; a hit is computed and
// written back, and a hit within the window then runs 40 divider steps.
// Flows fill the table in order from entry 0, so a fill count stands in for
// valid bits; reset empties the table at once, with no clearing pass.
// A stalled output holds one result; the next packet is taken meanwhile.
`default_nettype none
module per_flow_byte_rate_meter_core
  import frm_pkg::*;
#(
  parameter int FLOW_ENTRIES = 256,
  parameter int TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire pkt_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output res_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  frm_cmd_t  cmd;
  frm_stat_t stat;

  frm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  frm_dp #(
    .FLOW_ENTRIES(FLOW_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_COUNTED)) |->
      (out_data_o.flow_total == '0 && out_data_o.flow_rate == '0 && !out_data_o.new_window))
    else $error("dropped transaction carries counts");

  a_new_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.new_window) |->
      (out_data_o.flow_total == out_data_o.flow_rate))
    else $error("new window rate differs from total");

  a_rate_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_COUNTED)) |->
      (out_data_o.flow_rate <= out_data_o.flow_total))
    else $error("rate exceeds total");

endmodule
`default_nettype wire

// ===== tb/per_flow_byte_rate_meter_core_test.sv =====
`default_nettype none
module per_flow_byte_rate_meter_core_test;
  import frm_pkg::*;

  localparam int N_FLOWS = 256;
  localparam int POOL_N = 24;
  localparam int SETTLE_CYC = 700;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pkt_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  per_flow_byte_rate_meter_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // flow table copy; entries fill in order and are never evicted
  logic [15:0] win_ms = WINDOW_RESET;
  logic [7:0] hdr_bytes = LINK_HDR_RESET;
  int flow_cnt = 0;
  logic [31:0] flow_src [N_FLOWS];
  logic [31:0] flow_dst [N_FLOWS];
  logic [47:0] flow_start [N_FLOWS];
  logic [TOT_W-1:0] flow_bytes [N_FLOWS];

  res_out_t pending_res [$];
  logic [31:0] pool_src [POOL_N];
  logic [31:0] pool_dst [POOL_N];
  logic [47:0] cur_ms;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycle_cnt = 0;
  bit no_idle = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout at cycle %0d, %0d results outstanding", cycle_cnt, pending_res.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic res_out_t meter_predict(pkt_in_t p);
    res_out_t r;
    int hit;
    logic [47:0] elapsed;
    logic [63:0] secs;
    logic [TOT_W:0] sum;
    r = '0;
    hit = -1;
    if (p.wire_len != p.captured_len) begin
      r.status = ST_LEN_MISMATCH;
    end else if (p.eth_type != ETH_IPV4) begin
      r.status = ST_NOT_IPV4;
    end else if (p.captured_len < 16'(hdr_bytes) ||
                 p.ip_total_len != 16'(p.captured_len - 16'(hdr_bytes))) begin
      r.status = ST_IP_LEN_MISMATCH;
    end else begin
      for (int i = 0; i < flow_cnt; i++) begin
        if (hit < 0 && flow_src[i] == p.src_addr && flow_dst[i] == p.dst_addr) hit = i;
      end
      if (hit < 0 && flow_cnt == N_FLOWS) begin
        r.status = ST_TABLE_FULL;
      end else begin
        r.status = ST_COUNTED;
        if (hit < 0) begin
          hit = flow_cnt;
          flow_cnt++;
          flow_src[hit] = p.src_addr;
          flow_dst[hit] = p.dst_addr;
          elapsed = '1;
        end else begin
          elapsed = p.now_ms - flow_start[hit];
        end
        if (elapsed > 48'(win_ms)) begin
          flow_start[hit] = p.now_ms;
          flow_bytes[hit] = TOT_W'(p.captured_len);
          r.new_window = 1'b1;
          r.flow_total = TOT_W'(p.captured_len);
          r.flow_rate = TOT_W'(p.captured_len);
        end else begin
          sum = flow_bytes[hit] + TOT_W'(p.captured_len);
          flow_bytes[hit] = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
          secs = (64'(elapsed) + 64'd999) / 64'd1000;
          if (secs == 0) secs = 1;
          r.flow_total = flow_bytes[hit];
          r.flow_rate = TOT_W'(64'(flow_bytes[hit]) / secs);
        end
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    res_out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        n_errors++;
      end else begin
        w = pending_res.pop_front();
        cmp_field("status", TOT_W'(w.status), TOT_W'(out_data_o.status));
        cmp_field("new_window", TOT_W'(w.new_window), TOT_W'(out_data_o.new_window));
        cmp_field("flow_total", w.flow_total, out_data_o.flow_total);
        cmp_field("flow_rate", w.flow_rate, out_data_o.flow_rate);
        n_checked++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk_i);
        out_ready_i = 1'b1;
      end
      n = pick_gap();
      repeat (n) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
    end
  end

  task automatic send_pkt(pkt_in_t p);
    @(negedge clk_i);
    in_data_i = p;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_res.push_back(meter_predict(p));
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_res.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_WINDOW) win_ms = val;
    else if (idx == CFG_LINK_HDR) hdr_bytes = val[7:0];
  endtask

  function automatic pkt_in_t good_pkt(logic [31:0] s, logic [31:0] d, logic [15:0] clen,
                                       logic [47:0] t);
    pkt_in_t p;
    p.wire_len = clen;
    p.captured_len = clen;
    p.eth_type = ETH_IPV4;
    p.ip_total_len = clen - 16'(hdr_bytes);
    p.src_addr = s;
    p.dst_addr = d;
    p.now_ms = t;
    return p;
  endfunction

  function automatic logic [15:0] rand_clen();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(hdr_bytes, hdr_bytes + 1500));
    return 16'($urandom_range(hdr_bytes, 65535));
  endfunction

  task automatic test_drops();
    pkt_in_t p;
    p = good_pkt(32'h0a000001, 32'h0a000002, 16'd100, 48'd0);
    p.wire_len = 16'hffff;
    p.captured_len = 16'h0000;
    send_pkt(p);
    p.eth_type = 16'h86dd;  // both faults: length check wins
    send_pkt(p);
    p = good_pkt(32'h0a000001, 32'h0a000002, 16'd100, 48'd0);
    for (int b = 0; b < 16; b += 4) begin
      p.eth_type = ETH_IPV4 ^ (16'h1 << b);
      send_pkt(p);
    end
    p.eth_type = 16'hffff;
    send_pkt(p);
    p = good_pkt(32'h0a000001, 32'h0a000002, 16'd100, 48'd0);
    p.ip_total_len = p.ip_total_len + 16'd1;
    send_pkt(p);
    // capture shorter than link header: wrapped length still mismatches
    p = good_pkt(32'h0a000001, 32'h0a000002, 16'd5, 48'd0);
    p.ip_total_len = 16'd5 - 16'(hdr_bytes);
    send_pkt(p);
    p.ip_total_len = 16'hffff;
    send_pkt(p);
  endtask

  task automatic test_window_rules();
    logic [47:0] t0;
    t0 = 48'h0000_1234_5678;
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd14, t0));
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd1000, t0));
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd1500, t0 + 48'd999));
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd1500, t0 + 48'd1001));
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd64, t0 + 48'(win_ms)));
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd64, t0 + 48'(win_ms) + 48'd1));
    // time going backwards restarts the window
    send_pkt(good_pkt(32'h0a000001, 32'h0a000002, 16'd80, t0 + 48'd5));
    // reversed pair is a separate flow
    send_pkt(good_pkt(32'h0a000002, 32'h0a000001, 16'd80, t0 + 48'd5));
    // extremes, with time wrapping around the counter width
    send_pkt(good_pkt(32'hffffffff, 32'hffffffff, 16'hffff, 48'hffff_ffff_ffff));
    send_pkt(good_pkt(32'hffffffff, 32'hffffffff, 16'hffff, 48'd5));
    send_pkt(good_pkt(32'h00000000, 32'h00000000, 16'(hdr_bytes), 48'd0));
  endtask

  task automatic test_cfg_extremes();
    write_cfg(CFG_LINK_HDR, 16'd0);
    write_cfg(CFG_WINDOW, 16'd0);
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'd0, 48'd100));
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'd40, 48'd100));
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'd40, 48'd101));
    write_cfg(CFG_UNUSED, 16'hffff);
    write_cfg(CFG_LINK_HDR, 16'hffff);
    write_cfg(CFG_WINDOW, 16'hffff);
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'd255, 48'd200));
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'hffff, 48'd65735));
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'hffff, 48'd65736));
    send_pkt(good_pkt(32'h0b000001, 32'h0b000002, 16'd254, 48'd65737));
  endtask

  task automatic test_random(int n_items, logic [15:0] win, logic [7:0] hdr);
    pkt_in_t p;
    int k;
    int f;
    write_cfg(CFG_WINDOW, win);
    write_cfg(CFG_LINK_HDR, {8'h00, hdr});
    for (int i = 0; i < n_items; i++) begin
      no_idle = (i % 200) >= 150;
      k = $urandom_range(0, 99);
      if (k < 10) begin
        p.wire_len = 16'($urandom());
        p.captured_len = 16'($urandom());
        p.eth_type = 16'($urandom());
        p.ip_total_len = 16'($urandom());
        p.src_addr = $urandom();
        p.dst_addr = $urandom();
        p.now_ms = {16'($urandom()), 32'($urandom())};
        case ($urandom_range(0, 3))
          1: p.wire_len = p.captured_len;
          2: begin
            p.wire_len = p.captured_len;
            p.eth_type = ETH_IPV4;
          end
          3: begin
            p.wire_len = p.captured_len + 16'd1;
            p.eth_type = ETH_IPV4;
          end
          default: ;
        endcase
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) cur_ms = cur_ms + 48'($urandom_range(0, 32'(win) / 4 + 1));
        else if (k < 85) cur_ms = cur_ms + 48'($urandom_range(32'(win), 32'(win) + 2));
        else if (k < 95) cur_ms = cur_ms + 48'($urandom_range(0, 200000));
        else cur_ms = cur_ms - 48'($urandom_range(1, 5000));
        f = $urandom_range(0, POOL_N - 1);
        if ($urandom_range(0, 99) < 3)
          p = good_pkt($urandom(), $urandom(), rand_clen(), cur_ms);
        else
          p = good_pkt(pool_src[f], pool_dst[f], rand_clen(), cur_ms);
      end
      send_pkt(p);
      idle_gap();
    end
    no_idle = 1'b0;
  endtask

  // sender holds off after every tenth packet until every result is back, then resumes
  task automatic test_pressure();
    for (int i = 0; i < 30; i++) begin
      cur_ms = cur_ms + 48'($urandom_range(0, 300));
      send_pkt(good_pkt(pool_src[i % 4], pool_dst[i % 4], rand_clen(), cur_ms));
      if (i % 10 == 9) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait (pending_res.size() == 0);
      end
    end
  endtask

  task automatic test_table_full();
    int i;
    i = 0;
    while (flow_cnt < N_FLOWS) begin
      send_pkt(good_pkt(32'hc0a80000 + i, 32'h5a000000 ^ i, rand_clen(), cur_ms));
      i++;
      idle_gap();
    end
    for (int j = 0; j < 6; j++) begin
      send_pkt(good_pkt($urandom(), $urandom(), rand_clen(), cur_ms));
      cur_ms = cur_ms + 48'd10;
      send_pkt(good_pkt(flow_src[N_FLOWS - 1], flow_dst[N_FLOWS - 1], rand_clen(), cur_ms));
      send_pkt(good_pkt(flow_src[0], flow_dst[0], rand_clen(), cur_ms));
    end
  endtask

  initial begin
    foreach (pool_src[i]) begin
      pool_src[i] = $urandom();
      pool_dst[i] = $urandom();
    end
    cur_ms = {16'($urandom()), 32'($urandom())};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_drops();
    test_window_rules();
    test_cfg_extremes();
    test_random(400, WINDOW_RESET, LINK_HDR_RESET);
    test_pressure();
    test_random(300, 16'd0, 8'd0);
    test_random(400, 16'hffff, 8'hff);
    test_random(400, 16'($urandom_range(1, 10000)), 8'($urandom_range(0, 60)));
    test_table_full();

    drain();
    $display("sent %0d packets, checked %0d results, %0d flows stored, %0d mismatches",
             n_sent, n_checked, flow_cnt, n_errors);
    $display("covered drop codes, window limits, config extremes and a full flow table");
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
